[design/recursive_gaussian_column_filter_top_macros.svh]
// Assertion helpers for the column filter.
`ifndef RECURSIVE_GAUSSIAN_COLUMN_FILTER_TOP_MACROS_SVH
`define RECURSIVE_GAUSSIAN_COLUMN_FILTER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RGCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property checked in the cycle after its trigger.
`define RGCF_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

[design/rgcf_pkg.sv]
`default_nettype none

package rgcf_pkg;

  localparam int MAX_COLUMN_DEF = 2048;
  localparam int NUM_CH         = 3;
  localparam int PIX_W          = 8;
  localparam int GAIN_W         = 20;
  localparam int SEED_W         = 2 * GAIN_W;
  localparam int HIST_W         = 32;
  localparam int FRAC_W         = 16;
  localparam int BYTE_SUM_W     = HIST_W + 2;
  localparam int ROW_IDX_W      = 11;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [2:0] {
    REG_FWD_GAIN_NOW   = 3'd0,
    REG_FWD_GAIN_PREV  = 3'd1,
    REG_REV_GAIN_NEXT  = 3'd2,
    REG_REV_GAIN_AFTER = 3'd3,
    REG_FB_GAIN_ONE    = 3'd4,
    REG_FB_GAIN_TWO    = 3'd5,
    REG_EDGE_GAIN_FWD  = 3'd6,
    REG_EDGE_GAIN_REV  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] a0;
    logic signed [GAIN_W-1:0] a1;
    logic signed [GAIN_W-1:0] a2;
    logic signed [GAIN_W-1:0] a3;
    logic signed [GAIN_W-1:0] b1;
    logic signed [GAIN_W-1:0] b2;
    logic signed [GAIN_W-1:0] ef;
    logic signed [GAIN_W-1:0] er;
  } gains_t;

  // feedback gain times edge gain, used for the seeded first item
  typedef struct packed {
    logic signed [SEED_W-1:0] b1_ef;
    logic signed [SEED_W-1:0] b2_ef;
    logic signed [SEED_W-1:0] b1_er;
    logic signed [SEED_W-1:0] b2_er;
  } seeds_t;

  typedef struct packed {
    logic fire;
    logic rev;
    logic first;
  } chan_ctl_t;

  // Q.16 value to byte: truncate toward zero, clamp to 0..255
  function automatic logic [PIX_W-1:0] to_byte(input logic signed [BYTE_SUM_W-1:0] v);
    logic [PIX_W-1:0] b;
    if (v[BYTE_SUM_W-1]) begin
      b = '0;
    end else if (|v[BYTE_SUM_W-2:FRAC_W+PIX_W]) begin
      b = '1;
    end else begin
      b = v[FRAC_W+PIX_W-1:FRAC_W];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[design/rgcf_if.sv]
`default_nettype none

interface rgcf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic                        first;
  logic [rgcf_pkg::PIX_W-1:0]  in_red;
  logic [rgcf_pkg::PIX_W-1:0]  in_green;
  logic [rgcf_pkg::PIX_W-1:0]  in_blue;

  modport source (output valid, command, first, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, command, first, in_red, in_green, in_blue, output ready);
endinterface

interface rgcf_out_if;
  logic                            valid;
  logic                            ready;
  logic [rgcf_pkg::PIX_W-1:0]      out_red;
  logic [rgcf_pkg::PIX_W-1:0]      out_green;
  logic [rgcf_pkg::PIX_W-1:0]      out_blue;
  logic [rgcf_pkg::ROW_IDX_W-1:0]  row_index;

  modport source (output valid, out_red, out_green, out_blue, row_index, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, row_index, output ready);
endinterface

`default_nettype wire

[design/rgcf_ram.sv]
`default_nettype none

module rgcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = rgcf_pkg::MAX_COLUMN_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/rgcf_chan.sv]
`default_nettype none

module rgcf_chan (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rgcf_pkg::chan_ctl_t                 ctl,
  input  wire rgcf_pkg::gains_t                    gains,
  input  wire rgcf_pkg::seeds_t                    seeds,
  input  wire logic        [rgcf_pkg::PIX_W-1:0]   px,
  output logic signed      [rgcf_pkg::HIST_W-1:0]  y_nxt
);

  localparam int XW    = rgcf_pkg::PIX_W + 1;
  localparam int PW    = rgcf_pkg::GAIN_W + XW;
  localparam int SW    = PW + 1;
  localparam int FW    = rgcf_pkg::GAIN_W + rgcf_pkg::HIST_W;
  localparam int EW    = rgcf_pkg::SEED_W + XW;
  localparam int ACC_W = FW + 3;
  localparam int SH_W  = ACC_W - rgcf_pkg::FRAC_W;
  localparam int HW    = rgcf_pkg::HIST_W;

  logic        [rgcf_pkg::PIX_W-1:0]  ia_r, ib_r;
  logic signed [HW-1:0]               oa_r, ob_r;

  logic        [rgcf_pkg::PIX_W-1:0]  ia_eff, ib_eff, xn, xp;
  logic signed [XW-1:0]               px_s, xn_s, xp_s;
  logic signed [rgcf_pkg::GAIN_W-1:0] gn, gp, ge;
  logic signed [rgcf_pkg::SEED_W-1:0] s1, s2;
  logic signed [PW-1:0]               prod_n, prod_p, edge_h;
  logic signed [SW-1:0]               in_sum;
  logic signed [FW-1:0]               fb1_h, fb2_h, t1, t2;
  logic signed [EW-1:0]               seed1, seed2;
  logic signed [ACC_W-1:0]            acc;
  logic signed [SH_W-1:0]             sh;
  logic signed [HW-1:0]               oa_eff;

  always_comb begin
    ia_eff = ctl.first ? px : ia_r;
    ib_eff = ctl.first ? px : ib_r;
    xn     = ctl.rev ? ia_eff : px;
    xp     = ctl.rev ? ib_eff : ia_eff;
    px_s   = $signed({1'b0, px});
    xn_s   = $signed({1'b0, xn});
    xp_s   = $signed({1'b0, xp});
    gn     = ctl.rev ? gains.a2 : gains.a0;
    gp     = ctl.rev ? gains.a3 : gains.a1;
    ge     = ctl.rev ? gains.er : gains.ef;
    s1     = ctl.rev ? seeds.b1_er : seeds.b1_ef;
    s2     = ctl.rev ? seeds.b2_er : seeds.b2_ef;

    prod_n = gn * xn_s;
    prod_p = gp * xp_s;
    in_sum = {prod_n[PW-1], prod_n} + {prod_p[PW-1], prod_p};

    fb1_h  = gains.b1 * oa_r;
    fb2_h  = gains.b2 * ob_r;
    seed1  = s1 * px_s;
    seed2  = s2 * px_s;
    t1     = ctl.first ? {{(FW-EW){seed1[EW-1]}}, seed1} : fb1_h;
    t2     = ctl.first ? {{(FW-EW){seed2[EW-1]}}, seed2} : fb2_h;

    acc = {{(ACC_W-SW-rgcf_pkg::FRAC_W){in_sum[SW-1]}}, in_sum, {rgcf_pkg::FRAC_W{1'b0}}}
        - {{(ACC_W-FW){t1[FW-1]}}, t1}
        - {{(ACC_W-FW){t2[FW-1]}}, t2};

    // arithmetic shift gives floor, then clamp to signed 32 bits
    sh = acc[ACC_W-1:rgcf_pkg::FRAC_W];
    if (sh[SH_W-1:HW-1] == '0 || sh[SH_W-1:HW-1] == '1) begin
      y_nxt = sh[HW-1:0];
    end else if (sh[SH_W-1]) begin
      y_nxt = {1'b1, {(HW-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(HW-1){1'b1}}};
    end

    edge_h = ge * px_s;
    oa_eff = ctl.first ? {{(HW-PW){edge_h[PW-1]}}, edge_h} : oa_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ia_r <= '0;
      ib_r <= '0;
      oa_r <= '0;
      ob_r <= '0;
    end else if (ctl.fire) begin
      ia_r <= px;
      ib_r <= ctl.rev ? ia_eff : ib_r;
      ob_r <= oa_eff;
      oa_r <= y_nxt;
    end
  end

endmodule

`default_nettype wire

[design/recursive_gaussian_column_filter_top.sv]
// Column filter: second-order recursive Gaussian along one image column, RGB.
// in_ch  : valid/ready pixel channel (command, first, in_red/green/blue).
//          Send the column top to bottom with command 0, then bottom to top
//          with command 1; first marks the edge pixel of each pass.
// out_ch : valid/ready result channel, one transfer per reverse pixel, with
//          filtered bytes and row_index. Forward pixels give no transfer.
// cfg_*  : APB-style register port, 8 gain registers at 4*i, 20-bit signed.
// Throughput: one pixel per cycle while out_ch.ready keeps reverse pixels moving.
//          Each channel's recursion closes through one multiply-accumulate of four products.
// Path: an accepted reverse pixel moves from the input register to the middle
//          stage and then to the output register that drives out_ch.
// Reset: gains, filter history and row counter clear; the line store is
//          undefined until a forward pass writes it.
// Stall: the output register holds while out_ch.ready is low; a reverse
//          pixel waits in the middle stage, forward pixels keep draining,
//          and in_ch.ready drops once the input register is blocked.
`default_nettype none
`include "recursive_gaussian_column_filter_top_macros.svh"

module recursive_gaussian_column_filter_top #(
  parameter int MAX_COLUMN = rgcf_pkg::MAX_COLUMN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rgcf_in_if.sink                                in_ch,
  rgcf_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rgcf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [rgcf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [rgcf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int ADDR_W = $clog2(MAX_COLUMN);
  localparam int CNT_W  = $clog2(MAX_COLUMN + 1);
  localparam int NCH    = rgcf_pkg::NUM_CH;
  localparam int PW     = rgcf_pkg::PIX_W;
  localparam int HW     = rgcf_pkg::HIST_W;
  localparam int GW     = rgcf_pkg::GAIN_W;
  localparam int RW     = rgcf_pkg::ROW_IDX_W;
  localparam int BW     = rgcf_pkg::BYTE_SUM_W;
  localparam int FR     = rgcf_pkg::FRAC_W;

  // ---------------- configuration ----------------
  rgcf_pkg::gains_t   gains_r;
  rgcf_pkg::seeds_t   seeds_r;
  rgcf_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;
  logic signed [GW-1:0] cfg_val, rd_sel;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = rgcf_pkg::reg_idx_t'(cfg_paddr[rgcf_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_val    = cfg_pwdata[GW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgcf_pkg::REG_FWD_GAIN_NOW:   gains_r.a0 <= cfg_val;
        rgcf_pkg::REG_FWD_GAIN_PREV:  gains_r.a1 <= cfg_val;
        rgcf_pkg::REG_REV_GAIN_NEXT:  gains_r.a2 <= cfg_val;
        rgcf_pkg::REG_REV_GAIN_AFTER: gains_r.a3 <= cfg_val;
        rgcf_pkg::REG_FB_GAIN_ONE:    gains_r.b1 <= cfg_val;
        rgcf_pkg::REG_FB_GAIN_TWO:    gains_r.b2 <= cfg_val;
        rgcf_pkg::REG_EDGE_GAIN_FWD:  gains_r.ef <= cfg_val;
        rgcf_pkg::REG_EDGE_GAIN_REV:  gains_r.er <= cfg_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeds_r <= '0;
    end else begin
      seeds_r.b1_ef <= gains_r.b1 * gains_r.ef;
      seeds_r.b2_ef <= gains_r.b2 * gains_r.ef;
      seeds_r.b1_er <= gains_r.b1 * gains_r.er;
      seeds_r.b2_er <= gains_r.b2 * gains_r.er;
    end
  end

  always_comb begin
    case (cfg_idx)
      rgcf_pkg::REG_FWD_GAIN_NOW:   rd_sel = gains_r.a0;
      rgcf_pkg::REG_FWD_GAIN_PREV:  rd_sel = gains_r.a1;
      rgcf_pkg::REG_REV_GAIN_NEXT:  rd_sel = gains_r.a2;
      rgcf_pkg::REG_REV_GAIN_AFTER: rd_sel = gains_r.a3;
      rgcf_pkg::REG_FB_GAIN_ONE:    rd_sel = gains_r.b1;
      rgcf_pkg::REG_FB_GAIN_TWO:    rd_sel = gains_r.b2;
      rgcf_pkg::REG_EDGE_GAIN_FWD:  rd_sel = gains_r.ef;
      rgcf_pkg::REG_EDGE_GAIN_REV:  rd_sel = gains_r.er;
      default:                      rd_sel = '0;
    endcase
    cfg_prdata = {{(rgcf_pkg::CFG_DATA_W-GW){rd_sel[GW-1]}}, rd_sel};
  end

  // ---------------- pipeline control ----------------
  logic          s1_valid_r, s1_rev_r, s1_first_r;
  logic [PW-1:0] s1_px_r [NCH];
  logic          s2_valid_r;
  logic [ADDR_W-1:0] s2_pos_r;
  logic signed [HW-1:0] s2_y_r [NCH];
  logic          out_valid_r;
  logic [PW-1:0] out_px_r [NCH];
  logic [RW-1:0] out_row_r;

  logic out_en, s2_free, s1_fire, s2_fire, in_acc;

  assign out_en      = !out_valid_r || out_ch.ready;
  assign s2_free     = !s2_valid_r || out_en;
  assign s2_fire     = s2_valid_r && out_en;
  assign s1_fire     = s1_valid_r && (!s1_rev_r || s2_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rev_r   <= in_ch.command;
      s1_first_r <= in_ch.first;
      s1_px_r[0] <= in_ch.in_red;
      s1_px_r[1] <= in_ch.in_green;
      s1_px_r[2] <= in_ch.in_blue;
    end
  end

  // ---------------- filter channels ----------------
  rgcf_pkg::chan_ctl_t  ctl;
  logic signed [HW-1:0] y_nxt [NCH];

  assign ctl.fire  = s1_fire;
  assign ctl.rev   = s1_rev_r;
  assign ctl.first = s1_first_r;

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    rgcf_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .gains (gains_r),
      .seeds (seeds_r),
      .px    (s1_px_r[c]),
      .y_nxt (y_nxt[c])
    );
  end

  // ---------------- row counter and line store ----------------
  logic [CNT_W-1:0] rc_r, rc_nxt, rc_base, rc_dec;
  logic             fwd_store, ram_we, ram_re;
  logic [NCH*PW-1:0] ram_wdata, ram_rdata;

  always_comb begin
    rc_base   = s1_first_r ? '0 : rc_r;
    fwd_store = rc_base < CNT_W'(MAX_COLUMN);
    rc_dec    = (rc_r != '0) ? rc_r - CNT_W'(1) : rc_r;
    rc_nxt    = rc_r;
    if (s1_fire) begin
      if (s1_rev_r) begin
        rc_nxt = rc_dec;
      end else if (fwd_store) begin
        rc_nxt = rc_base + CNT_W'(1);
      end else begin
        rc_nxt = rc_base;
      end
    end
    for (int c = 0; c < NCH; c++) begin
      ram_wdata[c*PW +: PW] = rgcf_pkg::to_byte({{(BW-HW){y_nxt[c][HW-1]}}, y_nxt[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= '0;
    end else begin
      rc_r <= rc_nxt;
    end
  end

  assign ram_we = s1_fire && !s1_rev_r && fwd_store;
  assign ram_re = s1_fire && s1_rev_r;

  rgcf_ram #(
    .WIDTH (NCH * PW),
    .DEPTH (MAX_COLUMN)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rc_base[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rc_dec[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- result stages ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (ram_re) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s2_pos_r <= rc_dec[ADDR_W-1:0];
      s2_y_r   <= y_nxt;
    end
  end

  logic [PW-1:0]          out_px_nxt [NCH];
  logic [ADDR_W+RW-1:0]   pos_ext;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      out_px_nxt[c] = rgcf_pkg::to_byte(
          $signed({{(BW-PW-FR){1'b0}}, ram_rdata[c*PW +: PW], {FR{1'b0}}})
          + {{(BW-HW){s2_y_r[c][HW-1]}}, s2_y_r[c]});
    end
    pos_ext = (ADDR_W+RW)'(s2_pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_px_r  <= out_px_nxt;
      out_row_r <= pos_ext[RW-1:0];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_px_r[0];
  assign out_ch.out_green = out_px_r[1];
  assign out_ch.out_blue  = out_px_r[2];
  assign out_ch.row_index = out_row_r;

  // ---------------- assertions ----------------
  `RGCF_ASSERT(a_line_one_op, !(ram_we && ram_re), "line store read and write in one cycle")
  `RGCF_ASSERT(a_rc_bound, rc_r <= CNT_W'(MAX_COLUMN), "row counter above column length")
  `RGCF_ASSERT_NEXT(a_rev_to_s2, s1_fire && s1_rev_r, s2_valid_r, "reverse pixel lost after filter")
  `RGCF_ASSERT_NEXT(a_s2_hold, s2_valid_r && !out_en, s2_valid_r && $stable(s2_pos_r), "stalled result moved")

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int ROW_IDX_W      = rgcf_pkg::ROW_IDX_W;
  localparam int CFG_ADDR_W     = rgcf_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W     = rgcf_pkg::CFG_DATA_W;
  localparam int MAX_COLUMN_DEF = rgcf_pkg::MAX_COLUMN_DEF;

  localparam bit CMD_FWD = 1'b0;
  localparam bit CMD_REV = 1'b1;
  localparam int GAIN_MAX = 524287;
  localparam int GAIN_MIN = -524288;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -64'sh8000_0000;

  typedef struct {
    bit         command;
    bit         first;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } column_pixel_t;

  typedef struct {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [ROW_IDX_W-1:0] row;
  } filtered_pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rgcf_in_if  in_if ();
  rgcf_out_if out_if ();

  recursive_gaussian_column_filter_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  column_pixel_t   pixel_queue[$];
  filtered_pixel_t expected_pixels[$];
  column_pixel_t   drv_pixel;
  int  errors = 0;
  int  cycles = 0;
  int  res_count = 0;
  int  stall_left = 0;
  int  stalls_done = 0;
  bit  in_acc = 1'b0;
  bit  calm;

  // filter state mirror
  int         gain [8];
  logic [7:0] line_store [0:MAX_COLUMN_DEF-1][0:2];
  int         rows = 0;
  int         prev_px [3];
  int         prev2_px [3];
  int         y1 [3];
  int         y2 [3];

  assign calm = (cycles >= 1200) && (cycles < 2400);

  function automatic int floor_q16(longint s);
    longint q;
    q = s >>> 16;
    if (q > I32_MAX) return int'(I32_MAX);
    if (q < I32_MIN) return int'(I32_MIN);
    return int'(q);
  endfunction

  function automatic logic [7:0] q16_byte(longint v);
    longint whole;
    if (v < 0) return 8'h00;
    whole = v / 65536;
    return (whole > 255) ? 8'hFF : 8'(whole);
  endfunction

  task automatic filter_step(column_pixel_t it);
    int              px [3];
    int              y;
    longint          acc;
    logic [7:0]      res [3];
    filtered_pixel_t want;
    px[0] = it.red;
    px[1] = it.green;
    px[2] = it.blue;
    if (it.command == CMD_FWD) begin
      if (it.first) begin
        rows = 0;
        for (int c = 0; c < 3; c++) begin
          prev_px[c] = px[c];
          y1[c] = px[c] * gain[rgcf_pkg::REG_EDGE_GAIN_FWD];
          y2[c] = y1[c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        acc = (longint'(gain[rgcf_pkg::REG_FWD_GAIN_NOW]) * px[c]
             + longint'(gain[rgcf_pkg::REG_FWD_GAIN_PREV]) * prev_px[c]) * 65536
            - longint'(gain[rgcf_pkg::REG_FB_GAIN_ONE]) * y1[c]
            - longint'(gain[rgcf_pkg::REG_FB_GAIN_TWO]) * y2[c];
        y = floor_q16(acc);
        res[c] = q16_byte(longint'(y));
        prev_px[c] = px[c];
        y2[c] = y1[c];
        y1[c] = y;
      end
      // column too long: still filtered, not stored
      if (rows < MAX_COLUMN_DEF) begin
        for (int c = 0; c < 3; c++) line_store[rows][c] = res[c];
        rows++;
      end
    end else begin
      if (it.first) begin
        for (int c = 0; c < 3; c++) begin
          prev_px[c] = px[c];
          prev2_px[c] = px[c];
          y1[c] = px[c] * gain[rgcf_pkg::REG_EDGE_GAIN_REV];
          y2[c] = y1[c];
        end
      end
      if (rows > 0) rows--;
      for (int c = 0; c < 3; c++) begin
        acc = (longint'(gain[rgcf_pkg::REG_REV_GAIN_NEXT]) * prev_px[c]
             + longint'(gain[rgcf_pkg::REG_REV_GAIN_AFTER]) * prev2_px[c]) * 65536
            - longint'(gain[rgcf_pkg::REG_FB_GAIN_ONE]) * y1[c]
            - longint'(gain[rgcf_pkg::REG_FB_GAIN_TWO]) * y2[c];
        y = floor_q16(acc);
        prev2_px[c] = prev_px[c];
        prev_px[c] = px[c];
        y2[c] = y1[c];
        y1[c] = y;
        res[c] = q16_byte(longint'(line_store[rows][c]) * 65536 + y);
      end
      want.red = res[0];
      want.green = res[1];
      want.blue = res[2];
      want.row = ROW_IDX_W'(rows);
      expected_pixels.push_back(want);
    end
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // input side: transfer accepted, predict
  always @(posedge clk) begin
    in_acc <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      drv_pixel.command = in_if.command;
      drv_pixel.first = in_if.first;
      drv_pixel.red = in_if.in_red;
      drv_pixel.green = in_if.in_green;
      drv_pixel.blue = in_if.in_blue;
      filter_step(drv_pixel);
    end
  end

  // output side: compare
  always @(posedge clk) begin
    filtered_pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      res_count++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transfer, got row %0d rgb %0d %0d %0d", $time,
                 out_if.row_index, out_if.out_red, out_if.out_green, out_if.out_blue);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, out_if.out_red);
        check_field("out_green", want.green, out_if.out_green);
        check_field("out_blue", want.blue, out_if.out_blue);
        check_field("row_index", want.row, out_if.row_index);
      end
    end
  end

  always @(negedge clk) begin
    column_pixel_t nxt;
    if (!in_if.valid || in_acc) begin
      if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        nxt = pixel_queue.pop_front();
        in_if.command <= nxt.command;
        in_if.first <= nxt.first;
        in_if.in_red <= nxt.red;
        in_if.in_green <= nxt.green;
        in_if.in_blue <= nxt.blue;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    logic rdy;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (stalls_done < 2 && res_count >= 300 * (stalls_done + 1)
                 && pixel_queue.size() > 40) begin
      // long hold-off so the pipeline backs up into the input
      stall_left = 400;
      stalls_done++;
      rdy = 1'b0;
    end else begin
      rdy = calm || $urandom_range(99) >= 9;
    end
    out_if.ready <= rdy;
  end

  task automatic cfg_write(rgcf_pkg::reg_idx_t idx, int v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata <= CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    gain[idx] = v;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_gains(int a0, int a1, int a2, int a3, int b1, int b2, int ef, int er);
    cfg_write(rgcf_pkg::REG_FWD_GAIN_NOW, a0);
    cfg_write(rgcf_pkg::REG_FWD_GAIN_PREV, a1);
    cfg_write(rgcf_pkg::REG_REV_GAIN_NEXT, a2);
    cfg_write(rgcf_pkg::REG_REV_GAIN_AFTER, a3);
    cfg_write(rgcf_pkg::REG_FB_GAIN_ONE, b1);
    cfg_write(rgcf_pkg::REG_FB_GAIN_TWO, b2);
    cfg_write(rgcf_pkg::REG_EDGE_GAIN_FWD, ef);
    cfg_write(rgcf_pkg::REG_EDGE_GAIN_REV, er);
  endtask

  task automatic mild_gains();
    set_gains(int'($urandom_range(163840)) - 65536, int'($urandom_range(163840)) - 65536,
              int'($urandom_range(163840)) - 65536, int'($urandom_range(163840)) - 65536,
              int'($urandom_range(90000)) - 45000, int'($urandom_range(90000)) - 45000,
              int'($urandom_range(196608)) - 65536, int'($urandom_range(196608)) - 65536);
  endtask

  function automatic logic [7:0] some_byte();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_pixel(bit cmd, bit first_f, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    column_pixel_t p;
    p.command = cmd;
    p.first = first_f;
    p.red = r;
    p.green = g;
    p.blue = b;
    pixel_queue.push_back(p);
  endtask

  task automatic add_column(int len, int rev_len, bit seed_f, bit seed_r);
    for (int i = 0; i < len; i++)
      push_pixel(CMD_FWD, seed_f && i == 0, some_byte(), some_byte(), some_byte());
    for (int i = 0; i < rev_len; i++)
      push_pixel(CMD_REV, seed_r && i == 0, some_byte(), some_byte(), some_byte());
  endtask

  task automatic random_traffic(int budget, bit with_long);
    int added;
    int kind;
    int len;
    int rlen;
    added = 0;
    if (with_long) add_column(MAX_COLUMN_DEF + 4, 24, 1'b1, 1'b1);
    while (added < budget) begin
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      if (kind < 78) begin
        rlen = len + (($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0);
        add_column(len, rlen, $urandom_range(9) != 0, $urandom_range(9) != 0);
        added += len + rlen;
      end else if (kind < 90) begin
        push_pixel($urandom_range(1), $urandom_range(1), some_byte(), some_byte(),
                   some_byte());
        added++;
      end else if (kind < 95) begin
        rlen = $urandom_range(len - 1);
        add_column(len, rlen, 1'b1, 1'b1);
        added += len + rlen;
      end else begin
        add_column(0, len, 1'b0, $urandom_range(1));
        added += len;
      end
    end
  endtask

  task automatic drain();
    while (pixel_queue.size() != 0 || in_if.valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_FWD;
    in_if.first = 1'b0;
    in_if.in_red = '0;
    in_if.in_green = '0;
    in_if.in_blue = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_gains(32768, 16384, 16384, 8192, -19660, 6553, 65536, 32768);
    push_pixel(CMD_FWD, 1'b1, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_FWD, 1'b0, 8'd255, 8'd255, 8'd255);
    push_pixel(CMD_FWD, 1'b0, 8'd128, 8'd1, 8'd254);
    push_pixel(CMD_FWD, 1'b0, 8'd255, 8'd0, 8'd255);
    push_pixel(CMD_REV, 1'b1, 8'd255, 8'd255, 8'd255);
    push_pixel(CMD_REV, 1'b0, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_REV, 1'b0, 8'd7, 8'd200, 8'd90);
    push_pixel(CMD_REV, 1'b0, 8'd255, 8'd255, 8'd255);
    // past the top edge, row stays 0
    push_pixel(CMD_REV, 1'b0, 8'd1, 8'd2, 8'd3);
    push_pixel(CMD_REV, 1'b0, 8'd9, 8'd9, 8'd9);
    // passes without a seed
    push_pixel(CMD_FWD, 1'b0, 8'd10, 8'd20, 8'd30);
    push_pixel(CMD_FWD, 1'b0, 8'd40, 8'd50, 8'd60);
    push_pixel(CMD_REV, 1'b0, 8'd255, 8'd0, 8'd0);
    push_pixel(CMD_REV, 1'b0, 8'd0, 8'd255, 8'd0);
    push_pixel(CMD_REV, 1'b0, 8'd0, 8'd0, 8'd255);
    drain();

    mild_gains();
    random_traffic(270, 1'b0);
    drain();
    set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    random_traffic(270, 1'b0);
    drain();
    set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
    random_traffic(270, 1'b0);
    drain();
    mild_gains();
    random_traffic(270, 1'b0);
    drain();
    set_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, GAIN_MIN, GAIN_MAX, GAIN_MIN, GAIN_MAX);
    random_traffic(270, 1'b0);
    drain();
    mild_gains();
    random_traffic(270, 1'b0);
    drain();
    set_gains(65536, 0, 0, 0, 0, 0, 0, 0);
    random_traffic(270, 1'b0);
    drain();

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
